@@ rtl/core/bvm_pkg.sv @@
`timescale 1ns / 1ps
package bvm_pkg;

	localparam int STACK_DEPTH_DEF   = 16;
	localparam int MEM_BYTES_DEF     = 4096;
	localparam int SCREEN_WIDTH_DEF  = 64;
	localparam int SCREEN_HEIGHT_DEF = 32;

	localparam logic [1:0] ERR_NONE      = 2'd0;
	localparam logic [1:0] ERR_UNKNOWN   = 2'd1;
	localparam logic [1:0] ERR_OVERFLOW  = 2'd2;
	localparam logic [1:0] ERR_UNDERFLOW = 2'd3;

	localparam logic [1:0] MODE_EXEC   = 2'd0;
	localparam logic [1:0] MODE_WRITE  = 2'd1;
	localparam logic [1:0] MODE_READ   = 2'd2;
	localparam logic [1:0] MODE_UNUSED = 2'd3;  // no effect, reports state only

	localparam logic [15:0] PC_RESET = 16'h0200;
	localparam logic [15:0] OP_NOP   = 16'h0000;
	localparam logic [15:0] OP_CLS   = 16'h00E0;
	localparam logic [15:0] OP_RET   = 16'h00EE;

	// datapath commands issued by the controller
	typedef enum logic [3:0] {
		CMD_NONE,
		CMD_SIMPLE,    // opcode work done in one command
		CMD_CLR_ROW,   // clear row cnt
		CMD_MEM_WR,    // mode 1 write
		CMD_RD_REQ,    // memory read at I + cnt
		CMD_DRAW_ROW,  // xor fetched sprite byte into a row
		CMD_DRAW_END,
		CMD_ST_REG,    // store V[cnt] to I + cnt
		CMD_LD_REG,    // load fetched byte into V[cnt]
		CMD_BCD,       // store BCD digit cnt
		CMD_RET,
		CMD_CALL,
		CMD_HALT_UNK
	} cmd_t;

	typedef struct packed {
		cmd_t       cmd;
		logic [4:0] cnt;
	} ctl_t;

	typedef struct packed {
		logic       halted;
		logic [4:0] sp;
	} sts_t;

endpackage

@@ rtl/core/bvm_ctrl.sv @@
`timescale 1ns / 1ps
module bvm_ctrl
	import bvm_pkg::*;
#(
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [1:0]  mode,
	input  logic [15:0] opcode,
	input  sts_t        sts,
	output ctl_t        ctl,
	output logic        busy,
	output logic        done
);

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLS, ST_RD, ST_DRAW, ST_ST, ST_LD, ST_BCD, ST_FIN
	} state_t;

	state_t     state_q;
	logic [4:0] cnt_q;
	logic [4:0] last_q;
	logic [15:0] op_q;

	logic [3:0] hi, lo;
	logic [7:0] nn;
	assign hi = opcode[15:12];
	assign lo = opcode[3:0];
	assign nn = opcode[7:0];

	// controller sequencing
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			last_q  <= '0;
			op_q    <= '0;
			ctl     <= '{cmd: CMD_NONE, cnt: '0};
			busy    <= 1'b0;
			done    <= 1'b0;
		end else begin
			ctl  <= '{cmd: CMD_NONE, cnt: '0};
			done <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						busy  <= 1'b1;
						op_q  <= opcode;
						cnt_q <= '0;
						state_q <= ST_FIN;
						if (mode == MODE_WRITE) begin
							ctl.cmd <= CMD_MEM_WR;
						end else if (mode == MODE_EXEC && !sts.halted) begin
							priority if (opcode == OP_CLS) begin
								state_q <= ST_CLS;
							end else if (opcode == OP_RET) begin
								ctl.cmd <= (sts.sp == '0) ? CMD_HALT_UNK : CMD_RET;
							end else if (hi == 4'h0 && opcode != OP_NOP) begin
								ctl.cmd <= CMD_HALT_UNK;
							end else if (hi == 4'h2) begin
								ctl.cmd <= CMD_CALL;
							end else if (hi == 4'hD) begin
								last_q <= {1'b0, lo};
								if (lo == 4'h0) ctl.cmd <= CMD_DRAW_END;
								else state_q <= ST_RD;
							end else if (hi == 4'hF && nn == 8'h55) begin
								last_q <= {1'b0, opcode[11:8]};
								state_q <= ST_ST;
							end else if (hi == 4'hF && nn == 8'h65) begin
								last_q <= {1'b0, opcode[11:8]};
								state_q <= ST_RD;
							end else if (hi == 4'hF && lo == 4'h3) begin
								last_q <= 5'd2;
								state_q <= ST_BCD;
							end else if (hi != 4'h0) begin
								ctl.cmd <= CMD_SIMPLE;
							end
						end
					end
				end
				ST_CLS: begin
					ctl <= '{cmd: CMD_CLR_ROW, cnt: cnt_q};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'(SCREEN_HEIGHT - 1)) state_q <= ST_FIN;
				end
				ST_RD: begin
					ctl <= '{cmd: CMD_RD_REQ, cnt: cnt_q};
					state_q <= (op_q[15:12] == 4'hD) ? ST_DRAW : ST_LD;
				end
				ST_DRAW: begin
					ctl <= '{cmd: CMD_DRAW_ROW, cnt: cnt_q};
					cnt_q <= cnt_q + 5'd1;
					state_q <= (cnt_q + 5'd1 == last_q) ? ST_FIN : ST_RD;
				end
				ST_LD: begin
					ctl <= '{cmd: CMD_LD_REG, cnt: cnt_q};
					cnt_q <= cnt_q + 5'd1;
					state_q <= (cnt_q == last_q) ? ST_FIN : ST_RD;
				end
				ST_ST, ST_BCD: begin
					ctl <= '{cmd: (state_q == ST_ST) ? CMD_ST_REG : CMD_BCD, cnt: cnt_q};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == last_q) state_q <= ST_FIN;
				end
				ST_FIN: begin
					if (op_q[15:12] == 4'hD && last_q != '0 && cnt_q == last_q
					    && ctl.cmd != CMD_DRAW_END) begin
						ctl.cmd <= CMD_DRAW_END;
						cnt_q <= '0;
					end else begin
						done  <= 1'b1;
						busy  <= 1'b0;
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

@@ rtl/core/bvm_dp.sv @@
`timescale 1ns / 1ps
module bvm_dp
	import bvm_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int MEM_BYTES = MEM_BYTES_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        busy,
	input  logic [15:0] opcode,
	input  logic [15:0] key_mask,
	input  logic [7:0]  random_byte,
	input  logic [3:0]  waited_key,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  mem_data,
	input  logic [4:0]  row_select,
	input  ctl_t        ctl,
	output sts_t        sts,
	output logic [15:0] program_counter,
	output logic [15:0] index_value,
	output logic [7:0]  flag_register,
	output logic        halted,
	output logic [1:0]  error_code,
	output logic [63:0] display_row,
	output logic [7:0]  delay_value,
	output logic [7:0]  sound_value
);

	localparam int AW = $clog2(MEM_BYTES);
	localparam int SW = $clog2(STACK_DEPTH);

	logic [7:0]  v_q [16];
	logic [15:0] i_q, pc_q;
	logic [4:0]  sp_q;
	logic [7:0]  dt_q, st_q;
	logic        halt_q;
	logic [1:0]  err_q;
	logic [15:0] op_q, keys_q;
	logic [7:0]  rnd_q;
	logic [3:0]  wkey_q;
	logic [11:0] maddr_q;
	logic [7:0]  mdata_q;
	logic [4:0]  rsel_q;
	logic        hit_q;
	logic [63:0] frame_q [SCREEN_HEIGHT];
	logic [15:0] stack_q [STACK_DEPTH];
	logic [7:0]  mem_q [MEM_BYTES];
	logic [7:0]  rd_q;

	logic [3:0]  x, y, n;
	logic [7:0]  vx, vy, nn;
	logic [11:0] nnn;
	assign x = op_q[11:8];
	assign y = op_q[7:4];
	assign n = op_q[3:0];
	assign nn = op_q[7:0];
	assign nnn = op_q[11:0];
	assign vx = v_q[x];
	assign vy = v_q[y];

	// memory address of I plus step count
	logic [15:0] ia;
	logic [AW-1:0] ma;
	assign ia = i_q + 16'(ctl.cnt);
	assign ma = ia[AW-1:0];

	// bcd digits
	logic [7:0]  hund, tens, ones, rem, bcd_b;
	logic [15:0] q10;
	always_comb begin
		hund = (vx >= 8'd200) ? 8'd2 : (vx >= 8'd100) ? 8'd1 : 8'd0;
		rem  = vx - 8'(hund * 8'd100);
		// divide by ten with a reciprocal multiply, exact for every 8-bit rem
		q10  = 16'(rem) * 16'd205;
		tens = {3'd0, q10[15:11]};
		ones = rem - 8'(tens * 8'd10);
		unique case (ctl.cnt[1:0])
			2'd0: bcd_b = hund;
			2'd1: bcd_b = tens;
			default: bcd_b = ones;
		endcase
	end

	// sprite mask for current row
	logic [63:0] smask;
	logic [4:0]  drow;
	always_comb begin
		smask = '0;
		for (int j = 0; j < 8; j++)
			if (rd_q[7-j]) smask[6'(vx + 8'(j))] = 1'b1;
		drow = 5'(vy + 8'(ctl.cnt));
	end

	// memory
	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_MEM_WR) mem_q[maddr_q[AW-1:0]] <= mdata_q;
		if (ctl.cmd == CMD_ST_REG) mem_q[ma] <= v_q[ctl.cnt[3:0]];
		if (ctl.cmd == CMD_BCD) mem_q[ma] <= bcd_b;
		rd_q <= mem_q[ma];
	end

	always_ff @(posedge clk) begin
		if (ctl.cmd == CMD_CALL && sp_q < 5'(STACK_DEPTH))
			stack_q[sp_q[SW-1:0]] <= pc_q;
	end

	// item capture
	always_ff @(posedge clk) begin
		if (start && !busy) begin
			op_q <= opcode; keys_q <= key_mask; rnd_q <= random_byte;
			wkey_q <= waited_key; maddr_q <= mem_addr; mdata_q <= mem_data;
			rsel_q <= row_select;
		end
	end

	logic pressed;
	assign pressed = (vx < 8'd16) && keys_q[vx[3:0]];

	// architectural registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 16; k++) v_q[k] <= '0;
			for (int k = 0; k < SCREEN_HEIGHT; k++) frame_q[k] <= '0;
			i_q <= '0; pc_q <= PC_RESET; sp_q <= '0; dt_q <= '0; st_q <= '0;
			halt_q <= 1'b0; err_q <= ERR_NONE; hit_q <= 1'b0;
		end else begin
			unique case (ctl.cmd)
				CMD_CLR_ROW: frame_q[ctl.cnt] <= '0;
				CMD_RET: begin
					sp_q <= sp_q - 5'd1;
					pc_q <= stack_q[SW'(sp_q - 5'd1)];
				end
				CMD_HALT_UNK: begin
					halt_q <= 1'b1;
					err_q <= (op_q == OP_RET) ? ERR_UNDERFLOW : ERR_UNKNOWN;
				end
				CMD_CALL: begin
					sp_q <= sp_q + 5'd1;
					pc_q <= {4'h0, nnn};
					if (sp_q + 5'd1 >= 5'(STACK_DEPTH)) begin
						halt_q <= 1'b1; err_q <= ERR_OVERFLOW;
					end
				end
				CMD_DRAW_ROW: begin
					if (ctl.cnt == '0) hit_q <= |(frame_q[drow] & smask);
					else if (|(frame_q[drow] & smask)) hit_q <= 1'b1;
					frame_q[drow] <= frame_q[drow] ^ smask;
				end
				CMD_DRAW_END: v_q[15] <= (n == 4'h0) ? 8'd0 : {7'd0, hit_q};
				CMD_LD_REG: v_q[ctl.cnt[3:0]] <= rd_q;
				CMD_SIMPLE: begin
					unique case (op_q[15:12])
						4'h1: pc_q <= {4'h0, nnn};
						4'h3: if (vx == nn) pc_q <= pc_q + 16'd2;
						4'h4: if (vx != nn) pc_q <= pc_q + 16'd2;
						4'h5: if (vx == vy) pc_q <= pc_q + 16'd2;
						4'h6: v_q[x] <= nn;
						4'h7: v_q[x] <= vx + nn;
						4'h8: begin
							unique case (n)
								4'h0: v_q[x] <= vy;
								4'h1: v_q[x] <= vx | vy;
								4'h2: v_q[x] <= vx & vy;
								4'h3: v_q[x] <= vx ^ vy;
								4'h4: begin
									v_q[x] <= vx + vy;
									v_q[15] <= {7'd0, (9'(vx) + 9'(vy)) > 9'd255};
								end
								4'h5: begin
									v_q[x] <= vx - vy;
									v_q[15] <= {7'd0, vx > vy};
								end
								4'h6: begin
									v_q[x] <= vx >> 1;
									v_q[15] <= {7'd0, vx[0]};
								end
								4'h7: begin
									v_q[x] <= vy - vx;
									v_q[15] <= {7'd0, vy > vx};
								end
								4'hE: begin
									v_q[x] <= vx << 1;
									v_q[15] <= {7'd0, vx[7]};
								end
								default: begin halt_q <= 1'b1; err_q <= ERR_UNKNOWN; end
							endcase
						end
						4'h9: if (vx != vy) pc_q <= pc_q + 16'd2;
						4'hA: i_q <= {4'h0, nnn};
						4'hB: pc_q <= 16'(nnn) + 16'(v_q[0]);
						4'hC: v_q[x] <= rnd_q & nn;
						4'hE: begin
							if (n == 4'hE) begin
								if (pressed) pc_q <= pc_q + 16'd2;
							end else if (n == 4'h1) begin
								if (!pressed) pc_q <= pc_q + 16'd2;
							end else begin
								halt_q <= 1'b1; err_q <= ERR_UNKNOWN;
							end
						end
						4'hF: begin
							unique case (n)
								4'hA: v_q[x] <= {4'h0, wkey_q};
								4'h7: v_q[x] <= dt_q;
								4'h8: st_q <= vx;
								4'hE: i_q <= i_q + 16'(vx);
								4'h9: i_q <= 16'(vx) * 16'd5;
								4'h0: i_q <= 16'(vx);
								4'h5: begin
									if (nn == 8'h15) dt_q <= vx;
									else begin halt_q <= 1'b1; err_q <= ERR_UNKNOWN; end
								end
								default: begin halt_q <= 1'b1; err_q <= ERR_UNKNOWN; end
							endcase
						end
						default: ;
					endcase
				end
				default: ;
			endcase
		end
	end

	assign sts = '{halted: halt_q, sp: sp_q};
	assign program_counter = pc_q;
	assign index_value = i_q;
	assign flag_register = v_q[15];
	assign halted = halt_q;
	assign error_code = err_q;
	assign display_row = frame_q[rsel_q];
	assign delay_value = dt_q;
	assign sound_value = st_q;

endmodule

@@ rtl/core/byte_vm_instruction_executor.sv @@
`timescale 1ns / 1ps
// Executes one opcode word (mode 0), writes a memory byte (mode 1) or reads a
// display row (mode 2) per start; a word is taken when start is high and busy
// low, and its result appears for one cycle with done high, which cannot be
// stalled. DXYN, FX55, FX65, FX33 and 00E0 run longer than simple opcodes,
// paced by the single memory port and one row per cycle in the frame sequencer.
module byte_vm_instruction_executor
	import bvm_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int MEM_BYTES = MEM_BYTES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	output logic        done,
	input  logic [1:0]  mode,
	input  logic [15:0] opcode,
	input  logic [15:0] key_mask,
	input  logic [7:0]  random_byte,
	input  logic [3:0]  waited_key,
	input  logic [11:0] mem_addr,
	input  logic [7:0]  mem_data,
	input  logic [4:0]  row_select,
	output logic [15:0] program_counter,
	output logic [15:0] index_value,
	output logic [7:0]  flag_register,
	output logic        halted,
	output logic [1:0]  error_code,
	output logic [63:0] display_row,
	output logic [7:0]  delay_value,
	output logic [7:0]  sound_value
);

	ctl_t ctl;
	sts_t sts;

	bvm_ctrl #(.SCREEN_HEIGHT(SCREEN_HEIGHT_DEF)) u_ctrl (
		.clk, .arst_n, .start, .mode, .opcode, .sts, .ctl, .busy, .done
	);

	bvm_dp #(
		.STACK_DEPTH(STACK_DEPTH), .MEM_BYTES(MEM_BYTES),
		.SCREEN_HEIGHT(SCREEN_HEIGHT_DEF)
	) u_dp (
		.clk, .arst_n, .start, .busy, .opcode, .key_mask, .random_byte, .waited_key,
		.mem_addr, .mem_data, .row_select, .ctl, .sts, .program_counter,
		.index_value, .flag_register, .halted, .error_code, .display_row,
		.delay_value, .sound_value
	);

endmodule
